/* hdl/json_string_unescape_utf8_assert.svh */
// Assertion helpers for the string unescaper. Expect i_clk and i_rst_n in scope.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/jsu_pkg.sv */
`timescale 1ns / 1ps
package jsu_pkg;

    // result status codes
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_CLOSED  = 3'd1;
    localparam logic [2:0] ST_BAD_HEX = 3'd2;
    localparam logic [2:0] ST_BAD_ESC = 3'd3;
    localparam logic [2:0] ST_UNTERM  = 3'd4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_U      = 8'h75;

    // top six bits of a high / low surrogate
    localparam logic [5:0] SUR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SUR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPPL_BASE  = 21'h10000;

    localparam int JOB_Q_DEPTH = 4;
    localparam int JOB_Q_AW    = $clog2(JOB_Q_DEPTH);
    localparam int JOB_Q_CW    = $clog2(JOB_Q_DEPTH + 1);

    typedef enum logic [1:0] {
        SEG_NONE = 2'd0,
        SEG_RAW  = 2'd1,
        SEG_CP   = 2'd2,
        SEG_STAT = 2'd3
    } t_seg_kind;

    // one piece of output: a raw byte, a code point to encode, or a status
    typedef struct packed {
        t_seg_kind   kind;
        logic [20:0] val;
    } t_seg;

    // everything one input item produces, emitted first then second
    typedef struct packed {
        t_seg first;
        t_seg second;
    } t_job;

    function automatic t_seg mk_seg(input t_seg_kind kind, input logic [20:0] val);
        t_seg s;
        s.kind = kind;
        s.val  = val;
        return s;
    endfunction

    // {is_hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    // {is_simple_escape, byte}
    function automatic logic [8:0] simple_esc(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // UTF-8 length minus one
    function automatic logic [1:0] cp_len_m1(input logic [20:0] cp);
        logic [1:0] r;
        if (cp <= 21'h7F)
            r = 2'd0;
        else if (cp <= 21'h7FF)
            r = 2'd1;
        else if (cp <= 21'hFFFF)
            r = 2'd2;
        else
            r = 2'd3;
        return r;
    endfunction

    function automatic logic [7:0] cp_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                           input logic [1:0] pos);
        logic [7:0] r;
        case (len_m1)
            2'd0: r = {1'b0, cp[6:0]};
            2'd1: begin
                case (pos)
                    2'd0:    r = {3'b110, cp[10:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            2'd2: begin
                case (pos)
                    2'd0:    r = {4'b1110, cp[15:12]};
                    2'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (pos)
                    2'd0:    r = {5'b11110, cp[20:18]};
                    2'd1:    r = {2'b10, cp[17:12]};
                    2'd2:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

/* hdl/jsu_front.sv */
`timescale 1ns / 1ps
module jsu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] text_byte
    input  logic [0:0]       i_s_tuser,   // [0] text_end
    input  logic             i_q_full,
    output logic             o_push,
    output jsu_pkg::t_job    o_job
);

    typedef enum logic [5:0] {
        PH_PLAIN    = 6'b000001,
        PH_ESC      = 6'b000010,
        PH_HEX      = 6'b000100,
        PH_HIGH     = 6'b001000,
        PH_HIGH_ESC = 6'b010000,
        PH_PAIR_HEX = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [9:0]  r_pend,  n_pend;    // low ten bits of the held high surrogate
    logic [15:0] r_acc,   n_acc;
    logic [1:0]  r_cnt,   n_cnt;

    logic          accept;
    logic [7:0]    b;
    logic [4:0]    hx;
    logic [8:0]    se;
    logic [15:0]   acc_new;
    logic [20:0]   pend_cp;
    logic [20:0]   pair_cp;
    logic          new_high;
    logic          new_low;
    jsu_pkg::t_job job;
    logic          job_vld;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign b          = i_s_tdata;
    assign hx         = jsu_pkg::hex_digit(b);
    assign se         = jsu_pkg::simple_esc(b);
    assign acc_new    = {r_acc[11:0], hx[3:0]};
    assign pend_cp    = {5'd0, jsu_pkg::SUR_HIGH_TAG, r_pend};
    assign pair_cp    = jsu_pkg::SUPPL_BASE + {1'b0, r_pend, acc_new[9:0]};
    assign new_high   = acc_new[15:10] == jsu_pkg::SUR_HIGH_TAG;
    assign new_low    = acc_new[15:10] == jsu_pkg::SUR_LOW_TAG;

    always_comb begin
        n_phase    = r_phase;
        n_pend     = r_pend;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        job.first  = jsu_pkg::mk_seg(jsu_pkg::SEG_NONE, 21'd0);
        job.second = jsu_pkg::mk_seg(jsu_pkg::SEG_NONE, 21'd0);
        job_vld    = 1'b0;

        if (i_s_tuser[0]) begin
            job_vld    = 1'b1;
            job.second = jsu_pkg::mk_seg(jsu_pkg::SEG_STAT,
                             {18'd0, (r_phase == PH_HEX || r_phase == PH_PAIR_HEX) ?
                                     jsu_pkg::ST_BAD_HEX : jsu_pkg::ST_UNTERM});
            n_phase    = PH_PLAIN;
            n_cnt      = 2'd0;
        end else begin
            case (r_phase)
                PH_ESC, PH_HIGH_ESC: begin
                    if (b == jsu_pkg::CH_U) begin
                        n_phase = (r_phase == PH_ESC) ? PH_HEX : PH_PAIR_HEX;
                        n_acc   = 16'd0;
                        n_cnt   = 2'd0;
                    end else if (se[8]) begin
                        job_vld    = 1'b1;
                        if (r_phase == PH_HIGH_ESC)
                            job.first = jsu_pkg::mk_seg(jsu_pkg::SEG_CP, pend_cp);
                        job.second = jsu_pkg::mk_seg(jsu_pkg::SEG_RAW, {13'd0, se[7:0]});
                        n_phase    = PH_PLAIN;
                    end else begin
                        job_vld    = 1'b1;
                        job.second = jsu_pkg::mk_seg(jsu_pkg::SEG_STAT,
                                                     {18'd0, jsu_pkg::ST_BAD_ESC});
                        n_phase    = PH_PLAIN;
                    end
                end
                PH_HEX, PH_PAIR_HEX: begin
                    if (!hx[4]) begin
                        job_vld    = 1'b1;
                        job.second = jsu_pkg::mk_seg(jsu_pkg::SEG_STAT,
                                                     {18'd0, jsu_pkg::ST_BAD_HEX});
                        n_phase    = PH_PLAIN;
                        n_cnt      = 2'd0;
                    end else if (r_cnt != 2'd3) begin
                        n_acc = acc_new;
                        n_cnt = r_cnt + 2'd1;
                    end else begin
                        // fourth digit: the escape value is complete
                        n_acc = 16'd0;
                        n_cnt = 2'd0;
                        if (r_phase == PH_PAIR_HEX && new_low) begin
                            job_vld    = 1'b1;
                            job.second = jsu_pkg::mk_seg(jsu_pkg::SEG_CP, pair_cp);
                            n_phase    = PH_PLAIN;
                        end else begin
                            if (r_phase == PH_PAIR_HEX) begin
                                job_vld   = 1'b1;
                                job.first = jsu_pkg::mk_seg(jsu_pkg::SEG_CP, pend_cp);
                            end
                            if (new_high) begin
                                n_pend  = acc_new[9:0];
                                n_phase = PH_HIGH;
                            end else begin
                                job_vld    = 1'b1;
                                job.second = jsu_pkg::mk_seg(jsu_pkg::SEG_CP,
                                                             {5'd0, acc_new});
                                n_phase    = PH_PLAIN;
                            end
                        end
                    end
                end
                PH_HIGH: begin
                    if (b == jsu_pkg::CH_BSLASH) begin
                        n_phase = PH_HIGH_ESC;
                    end else begin
                        job_vld   = 1'b1;
                        job.first = jsu_pkg::mk_seg(jsu_pkg::SEG_CP, pend_cp);
                        if (b == jsu_pkg::CH_QUOTE)
                            job.second = jsu_pkg::mk_seg(jsu_pkg::SEG_STAT,
                                                         {18'd0, jsu_pkg::ST_CLOSED});
                        else
                            job.second = jsu_pkg::mk_seg(jsu_pkg::SEG_RAW, {13'd0, b});
                        n_phase = PH_PLAIN;
                    end
                end
                default: begin
                    if (b == jsu_pkg::CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else if (b == jsu_pkg::CH_QUOTE) begin
                        job_vld    = 1'b1;
                        job.second = jsu_pkg::mk_seg(jsu_pkg::SEG_STAT,
                                                     {18'd0, jsu_pkg::ST_CLOSED});
                        n_phase    = PH_PLAIN;
                    end else begin
                        job_vld    = 1'b1;
                        job.second = jsu_pkg::mk_seg(jsu_pkg::SEG_RAW, {13'd0, b});
                        n_phase    = PH_PLAIN;
                    end
                end
            endcase
        end
    end

    assign o_push = accept && job_vld;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_cnt   <= 2'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
            r_acc  <= n_acc;
        end
    end

endmodule

/* hdl/jsu_job_queue.sv */
`timescale 1ns / 1ps
module jsu_job_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output jsu_pkg::t_job o_job,
    output logic          o_empty
);

    jsu_pkg::t_job                  r_mem [jsu_pkg::JOB_Q_DEPTH];
    logic [jsu_pkg::JOB_Q_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [jsu_pkg::JOB_Q_CW-1:0]   r_count;
    logic                           do_push, do_pop;

    localparam logic [jsu_pkg::JOB_Q_AW-1:0] LAST_PTR =
        jsu_pkg::JOB_Q_AW'(jsu_pkg::JOB_Q_DEPTH - 1);
    localparam logic [jsu_pkg::JOB_Q_CW-1:0] FULL_COUNT =
        jsu_pkg::JOB_Q_CW'(jsu_pkg::JOB_Q_DEPTH);
    localparam logic [jsu_pkg::JOB_Q_AW-1:0] PTR_ONE = jsu_pkg::JOB_Q_AW'(1);
    localparam logic [jsu_pkg::JOB_Q_CW-1:0] CNT_ONE = jsu_pkg::JOB_Q_CW'(1);

    assign o_full  = r_count == FULL_COUNT;
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push)
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_ONE;
            if (do_pop)
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_ONE;
            if (do_push && !do_pop)
                r_count <= r_count + CNT_ONE;
            else if (do_pop && !do_push)
                r_count <= r_count - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr_ptr] <= i_job;
    end

endmodule

/* hdl/jsu_back.sv */
`timescale 1ns / 1ps
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  jsu_pkg::t_job i_job,
    input  logic          i_q_empty,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [7:0]    o_m_tdata,   // [7:0] out_byte
    output logic [3:0]    o_m_tuser,   // [0] byte_valid, [3:1] status
    output logic          o_m_tlast    // run_last
);

    jsu_pkg::t_job r_job;
    logic          r_have;
    logic          r_seg_sel;   // 0: first segment, 1: second
    logic [1:0]    r_pos;       // byte within the segment

    logic          r_m_tvalid;
    logic [7:0]    r_m_tdata;
    logic [3:0]    r_m_tuser;
    logic          r_m_tlast;

    jsu_pkg::t_seg cur;
    logic [1:0]    len_m1;
    logic          seg_done, job_done, adv;
    logic [7:0]    res_byte;
    logic          res_vld;
    logic [2:0]    res_stat;

    assign cur      = r_seg_sel ? r_job.second : r_job.first;
    assign len_m1   = (cur.kind == jsu_pkg::SEG_CP) ? jsu_pkg::cp_len_m1(cur.val) : 2'd0;
    assign seg_done = r_pos == len_m1;
    assign job_done = seg_done && (r_seg_sel || r_job.second.kind == jsu_pkg::SEG_NONE);
    assign adv      = r_have && (!r_m_tvalid || i_m_tready);
    assign o_pop    = !i_q_empty && (!r_have || (adv && job_done));

    always_comb begin
        res_byte = 8'd0;
        res_vld  = 1'b0;
        res_stat = jsu_pkg::ST_BUSY;
        case (cur.kind)
            jsu_pkg::SEG_RAW: begin
                res_byte = cur.val[7:0];
                res_vld  = 1'b1;
            end
            jsu_pkg::SEG_CP: begin
                res_byte = jsu_pkg::cp_byte(cur.val, len_m1, r_pos);
                res_vld  = 1'b1;
            end
            jsu_pkg::SEG_STAT: res_stat = cur.val[2:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_seg_sel  <= 1'b0;
            r_pos      <= 2'd0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have    <= 1'b1;
                r_seg_sel <= i_job.first.kind == jsu_pkg::SEG_NONE;
                r_pos     <= 2'd0;
            end else if (adv && job_done) begin
                r_have <= 1'b0;
            end else if (adv) begin
                if (seg_done) begin
                    r_seg_sel <= 1'b1;
                    r_pos     <= 2'd0;
                end else begin
                    r_pos <= r_pos + 2'd1;
                end
            end
            if (adv)
                r_m_tvalid <= 1'b1;
            else if (i_m_tready)
                r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_job <= i_job;
        if (adv) begin
            r_m_tdata <= res_byte;
            r_m_tuser <= {res_stat, res_vld};
            r_m_tlast <= job_done;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_tlast;

endmodule

/* hdl/json_string_unescape_utf8.sv */
`timescale 1ns / 1ps
// JSON string body unescaper: feed the bytes after the opening quote, one per transfer,
// with tuser set for end of text; decoded UTF-8 bytes and status events come out one per
// transfer, tlast marking the last result of each input byte. A front decoder takes one
// input byte per cycle while the job queue has room and queues a job describing its output;
// a back end emits one result per cycle from that job while the output is not stalled.
// Plain bytes and simple escapes therefore sustain one byte per cycle, while a byte that
// produces n results (up to six, for a surrogate that turns out unpaired followed by a
// 3-byte value) keeps the back end busy until all n are out; input stalls only once the
// 4-entry job queue fills. A result passes through the queue, the job register and the output register.
`include "json_string_unescape_utf8_assert.svh"
module json_string_unescape_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  logic [0:0] i_s_tuser,   // [0] text_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [3:0] o_m_tuser,   // [0] byte_valid, [3:1] status
    output logic       o_m_tlast    // run_last
);

    logic          q_push, q_pop, q_full, q_empty;
    jsu_pkg::t_job push_job, pop_job;

    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    jsu_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (pop_job),
        .o_empty (q_empty)
    );

    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (pop_job),
        .i_q_empty  (q_empty),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    `JSU_ASSERT_NOW(a_push_room, q_push, !q_full, "job pushed into a full queue")
    `JSU_ASSERT_NEXT(a_pop_frees, q_full && q_pop, !q_full, "queue stayed full after a pop")
    `JSU_ASSERT_NOW(a_status_last, o_m_tvalid && !o_m_tuser[0], o_m_tlast, "status not last")
    `JSU_ASSERT_NOW(a_byte_busy, o_m_tvalid && o_m_tuser[0],
                    o_m_tuser[3:1] == jsu_pkg::ST_BUSY, "byte result with nonzero status")

endmodule

/* test/json_string_unescape_utf8_tb.sv */
`timescale 1ns / 1ps
module json_string_unescape_utf8_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_TAIL     = 20;
    localparam int ITEMS_PER_MIX  = 75;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LB      = 8'h62;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_LN      = 8'h6E;
    localparam logic [7:0] CH_LR      = 8'h72;
    localparam logic [7:0] CH_LT      = 8'h74;
    localparam logic [7:0] CH_LQ      = 8'h71;
    localparam logic [7:0] CH_UG      = 8'h47;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    localparam logic [7:0]  ESC_LETTERS [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                                                 CH_SLASH, CH_LB, CH_LF, CH_LN, CH_LR, CH_LT};
    localparam logic [15:0] EDGE_UNITS [8]  = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                                 16'h0800, 16'hFFFF, 16'hD7FF, 16'hE000};

    // send-side idle / receive-side stall percentages per handshake mix
    localparam int SEND_IDLE  [4] = '{0, 76, 0, 21};
    localparam int RECV_STALL [4] = '{0, 0, 76, 21};

    typedef enum logic [2:0] {
        P_PLAIN,
        P_ESC,
        P_HEX,
        P_HIGH,
        P_HIGH_ESC,
        P_PAIR_HEX
    } t_dec_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic [2:0] status;
        logic       last;
    } t_utf8_result;

    class utf8_decode_board;
        t_utf8_result expected_out[$];
        t_dec_phase   dphase;
        logic [15:0]  held_high;
        logic [15:0]  hex_acc;
        int           hex_cnt;
        t_utf8_result step_res [6];
        int           step_n;
        int           n_in, n_out, n_closed, n_err, errors;

        function new();
            clear_state();
            n_in = 0;
            n_out = 0;
            n_closed = 0;
            n_err = 0;
            errors = 0;
        endfunction

        function void clear_state();
            dphase    = P_PLAIN;
            held_high = '0;
            hex_acc   = '0;
            hex_cnt   = 0;
        endfunction

        static function int hex_value(input logic [7:0] c);
            if (c >= CH_DIGIT0 && c <= CH_DIGIT9)
                return int'(c) - int'(CH_DIGIT0);
            if (c >= CH_LOWER_A && c <= CH_LF)
                return int'(c) - int'(CH_LOWER_A) + 10;
            if (c >= CH_UPPER_A && c <= CH_UPPER_F)
                return int'(c) - int'(CH_UPPER_A) + 10;
            return -1;
        endfunction

        static function int escape_byte(input logic [7:0] c);
            case (c)
                jsu_pkg::CH_QUOTE:  return int'(jsu_pkg::CH_QUOTE);
                jsu_pkg::CH_BSLASH: return int'(jsu_pkg::CH_BSLASH);
                CH_SLASH:           return int'(CH_SLASH);
                CH_LB:              return 'h08;  // backspace
                CH_LF:              return 'h0C;  // form feed
                CH_LN:              return 'h0A;
                CH_LR:              return 'h0D;
                CH_LT:              return 'h09;
                default:            return -1;
            endcase
        endfunction

        function void put(input logic [7:0] d, input logic v, input logic [2:0] st);
            if (step_n < 6) begin
                step_res[step_n] = '{data: d, valid: v, status: st, last: 1'b0};
                step_n++;
            end
        endfunction

        function void put_cp(input logic [20:0] cp);
            if (cp <= 21'h7F) begin
                put({1'b0, cp[6:0]}, 1'b1, jsu_pkg::ST_BUSY);
            end else if (cp <= 21'h7FF) begin
                put({3'b110, cp[10:6]}, 1'b1, jsu_pkg::ST_BUSY);
                put({2'b10, cp[5:0]}, 1'b1, jsu_pkg::ST_BUSY);
            end else if (cp <= 21'hFFFF) begin
                put({4'b1110, cp[15:12]}, 1'b1, jsu_pkg::ST_BUSY);
                put({2'b10, cp[11:6]}, 1'b1, jsu_pkg::ST_BUSY);
                put({2'b10, cp[5:0]}, 1'b1, jsu_pkg::ST_BUSY);
            end else begin
                put({5'b11110, cp[20:18]}, 1'b1, jsu_pkg::ST_BUSY);
                put({2'b10, cp[17:12]}, 1'b1, jsu_pkg::ST_BUSY);
                put({2'b10, cp[11:6]}, 1'b1, jsu_pkg::ST_BUSY);
                put({2'b10, cp[5:0]}, 1'b1, jsu_pkg::ST_BUSY);
            end
        endfunction

        function void fail(input logic [2:0] st);
            put(8'h00, 1'b0, st);
            clear_state();
        endfunction

        // completed escape value: a high surrogate waits for its partner
        function void take_value(input logic [15:0] cp);
            hex_acc = '0;
            hex_cnt = 0;
            if (cp[15:10] == jsu_pkg::SUR_HIGH_TAG) begin
                held_high = cp;
                dphase    = P_HIGH;
            end else begin
                put_cp({5'd0, cp});
                held_high = '0;
                dphase    = P_PLAIN;
            end
        endfunction

        function void note_text_byte(input logic [7:0] c, input logic is_end);
            int           v;
            logic [15:0]  cp;
            t_utf8_result r;
            step_n = 0;
            n_in++;
            if (is_end) begin
                fail((dphase == P_HEX || dphase == P_PAIR_HEX) ?
                     jsu_pkg::ST_BAD_HEX : jsu_pkg::ST_UNTERM);
            end else begin
                case (dphase)
                    P_ESC, P_HIGH_ESC: begin
                        if (c == jsu_pkg::CH_U) begin
                            dphase  = (dphase == P_ESC) ? P_HEX : P_PAIR_HEX;
                            hex_acc = '0;
                            hex_cnt = 0;
                        end else begin
                            v = escape_byte(c);
                            if (v < 0) begin
                                fail(jsu_pkg::ST_BAD_ESC);
                            end else begin
                                if (dphase == P_HIGH_ESC)
                                    put_cp({5'd0, held_high});
                                put(v[7:0], 1'b1, jsu_pkg::ST_BUSY);
                                clear_state();
                            end
                        end
                    end
                    P_HEX, P_PAIR_HEX: begin
                        v = hex_value(c);
                        if (v < 0) begin
                            fail(jsu_pkg::ST_BAD_HEX);
                        end else begin
                            hex_acc = {hex_acc[11:0], v[3:0]};
                            hex_cnt++;
                            if (hex_cnt >= 4) begin
                                cp = hex_acc;
                                if (dphase == P_HEX) begin
                                    take_value(cp);
                                end else if (cp[15:10] == jsu_pkg::SUR_LOW_TAG) begin
                                    put_cp(jsu_pkg::SUPPL_BASE +
                                           {1'b0, held_high[9:0], cp[9:0]});
                                    clear_state();
                                end else begin
                                    // second escape is no low half: flush the high one
                                    put_cp({5'd0, held_high});
                                    take_value(cp);
                                end
                            end
                        end
                    end
                    P_HIGH: begin
                        if (c == jsu_pkg::CH_BSLASH) begin
                            dphase = P_HIGH_ESC;
                        end else begin
                            put_cp({5'd0, held_high});
                            if (c == jsu_pkg::CH_QUOTE)
                                put(8'h00, 1'b0, jsu_pkg::ST_CLOSED);
                            else
                                put(c, 1'b1, jsu_pkg::ST_BUSY);
                            clear_state();
                        end
                    end
                    default: begin
                        if (c == jsu_pkg::CH_BSLASH) begin
                            dphase = P_ESC;
                        end else if (c == jsu_pkg::CH_QUOTE) begin
                            put(8'h00, 1'b0, jsu_pkg::ST_CLOSED);
                            clear_state();
                        end else begin
                            put(c, 1'b1, jsu_pkg::ST_BUSY);
                            dphase = P_PLAIN;
                        end
                    end
                endcase
            end
            for (int i = 0; i < step_n; i++) begin
                r      = step_res[i];
                r.last = (i == step_n - 1);
                expected_out.push_back(r);
            end
        endfunction

        function void check_output(input logic [7:0] d, input logic [3:0] u, input logic l);
            t_utf8_result want, got;
            got = '{data: d, valid: u[0], status: u[3:1], last: l};
            n_out++;
            if (expected_out.size() == 0) begin
                errors++;
                $display("%0t: unexpected result data=%h valid=%b status=%0d last=%b",
                         $time, got.data, got.valid, got.status, got.last);
                return;
            end
            want = expected_out.pop_front();
            if (want.status == jsu_pkg::ST_CLOSED)
                n_closed++;
            else if (want.status != jsu_pkg::ST_BUSY)
                n_err++;
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch, expected %h %b %0d %b, got %h %b %0d %b",
                         $time, want.data, want.valid, want.status, want.last,
                         got.data, got.valid, got.status, got.last);
            end
        endfunction

        function int pending();
            return expected_out.size();
        endfunction
    endclass

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] text_byte
    logic [0:0] s_tuser  = 1'b0;    // [0] text_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic [3:0] m_tuser;            // [0] byte_valid, [3:1] status
    logic       m_tlast;

    utf8_decode_board board = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_sent         = 0;
    int hold_req       = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    bit long_hold_done = 1'b0;

    json_string_unescape_utf8 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            board.check_output(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("[json_string_unescape_utf8] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10)
            return CH_DIGIT0 + {4'd0, nib};
        return (upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, nib} - 8'd10;
    endfunction

    function automatic logic [7:0] rand_bad_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (utf8_decode_board::hex_value(c) >= 0);
        return c;
    endfunction

    function automatic logic [15:0] rand_code_unit();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 'h7F));
            1:       return 16'($urandom_range('h80, 'h7FF));
            2:       return 16'($urandom_range('h800, 'hFFFF));
            3:       return 16'($urandom_range('hD800, 'hDBFF));
            4:       return 16'($urandom_range('hDC00, 'hDFFF));
            default: return EDGE_UNITS[$urandom_range(0, 7)];
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic [7:0] c, input logic is_end);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= is_end;
        do
            @(posedge i_clk);
        while (!s_tready);
        board.note_text_byte(c, is_end);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_u_escape(input logic [15:0] unit);
        send_item(jsu_pkg::CH_BSLASH, 1'b0);
        send_item(jsu_pkg::CH_U, 1'b0);
        for (int i = 3; i >= 0; i--)
            send_item(hex_char(unit[i*4 +: 4], 1'($urandom_range(0, 1))), 1'b0);
    endtask

    // \u with fewer than four digits, then a non-hex byte or end of text
    task automatic send_u_bad();
        int digits;
        digits = $urandom_range(0, 3);
        send_item(jsu_pkg::CH_BSLASH, 1'b0);
        send_item(jsu_pkg::CH_U, 1'b0);
        repeat (digits)
            send_item(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
        if ($urandom_range(0, 1) == 0)
            send_item(rand_bad_hex(), 1'b0);
        else
            send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == jsu_pkg::CH_BSLASH);
        send_item(c, 1'b0);
    endtask

    task automatic send_random_segment();
        int k;
        k = $urandom_range(0, 99);
        if (k < 25) begin
            send_plain();
        end else if (k < 40) begin
            send_item(jsu_pkg::CH_BSLASH, 1'b0);
            send_item(ESC_LETTERS[$urandom_range(0, 7)], 1'b0);
        end else if (k < 58) begin
            send_u_escape(rand_code_unit());
        end else if (k < 70) begin
            send_u_escape(16'hD800 | 16'($urandom_range(0, 1023)));
            send_u_escape(16'hDC00 | 16'($urandom_range(0, 1023)));
        end else if (k < 82) begin
            // high half followed by a random item, which can also be a proper low half
            send_u_escape(16'hD800 | 16'($urandom_range(0, 1023)));
            case ($urandom_range(0, 6))
                0: send_plain();
                1: send_item(jsu_pkg::CH_QUOTE, 1'b0);
                2: begin
                    send_item(jsu_pkg::CH_BSLASH, 1'b0);
                    send_item(ESC_LETTERS[$urandom_range(0, 7)], 1'b0);
                end
                3: send_u_escape(rand_code_unit());
                4: begin
                    send_item(jsu_pkg::CH_BSLASH, 1'b0);
                    send_item(8'($urandom_range(0, 255)), 1'b0);
                end
                5: send_u_bad();
                default: send_item(8'($urandom_range(0, 255)), 1'b1);
            endcase
        end else if (k < 87) begin
            send_item(jsu_pkg::CH_QUOTE, 1'b0);
        end else if (k < 93) begin
            send_item(jsu_pkg::CH_BSLASH, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end else if (k < 97) begin
            send_u_bad();
        end else begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (board.pending() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int target;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: byte extremes, simple escapes, a surrogate pair in mixed case,
        // closing quote, unknown escape, bad hex digit, end of text
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(jsu_pkg::CH_BSLASH, 1'b0);
        send_item(CH_LT, 1'b0);
        send_item(jsu_pkg::CH_BSLASH, 1'b0);
        send_item(jsu_pkg::CH_QUOTE, 1'b0);
        send_u_escape(16'hD83D);
        send_u_escape(16'hDE00);
        send_item(jsu_pkg::CH_QUOTE, 1'b0);
        send_item(jsu_pkg::CH_BSLASH, 1'b0);
        send_item(CH_LQ, 1'b0);
        send_item(jsu_pkg::CH_BSLASH, 1'b0);
        send_item(jsu_pkg::CH_U, 1'b0);
        send_item(CH_UG, 1'b0);
        send_item(8'h5A, 1'b1);
        wait_drained();

        for (int mix = 0; mix < 4; mix++) begin
            send_idle_pct  = SEND_IDLE[mix];
            recv_stall_pct = RECV_STALL[mix];
            target = n_sent + ITEMS_PER_MIX;
            while (n_sent < target) begin
                // back-pressure burst while input keeps streaming
                if (mix == 0 && !long_hold_done && n_sent >= target - 60) begin
                    long_hold_done = 1'b1;
                    hold_req       = 1;
                end
                send_random_segment();
            end
            wait_drained();
        end

        repeat (DRAIN_TAIL) @(posedge i_clk);
        $display("covered %0d inputs, %0d results, %0d closes, %0d error events",
                 board.n_in, board.n_out, board.n_closed, board.n_err);
        $display("mixes: full rate, sparse input, output stalls, both, one long hold-off");
        if (board.errors == 0 && board.pending() == 0)
            $display("[json_string_unescape_utf8] OK");
        else
            $display("[json_string_unescape_utf8] ERROR");
        $finish;
    end

endmodule
